@@ rtl/tld_pkg.sv @@
// Types, character codes and register indexes of the tty line discipline.
// Used by tld_out_seq and tty_line_discipline_unit; depends on nothing.
package tld_pkg;

    localparam int LINE_DEPTH_DEF = 256;
    localparam int CFG_W          = 16;
    localparam int CFG_IDX_W      = 3;

    // request codes
    localparam logic [1:0] REQ_RX    = 2'd0;
    localparam logic [1:0] REQ_READ  = 2'd1;
    localparam logic [1:0] REQ_WRITE = 2'd2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_CANON  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ECHO   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CRNL   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SIG    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_ONLCR  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_INTR   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_EOF    = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_FG     = 3'd7;

    // character codes
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_BS    = 8'h08;
    localparam logic [7:0] CH_NL    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SP    = 8'h20;
    localparam logic [7:0] CH_CARET = 8'h5E;
    localparam logic [7:0] CH_C     = 8'h43;
    localparam logic [7:0] CH_DEL   = 8'h7F;
    localparam logic [7:0] INTR_RST = 8'h03;
    localparam logic [7:0] EOF_RST  = 8'h04;

    typedef struct packed {
        logic [1:0] req_type;
        logic [7:0] char_in;
    } t_item;

    typedef struct packed {
        logic        tx_valid;
        logic [7:0]  tx_char;
        logic        read_valid;
        logic [7:0]  read_data;
        logic        read_ends_line;
        logic        interrupt_fire;
        logic [15:0] interrupt_target;
        logic        last;
    } t_result;

    // all results caused by one item
    typedef struct packed {
        logic [2:0]      cnt;
        logic            txv;
        logic [3:0][7:0] bytes;
        logic            rv;
        logic [7:0]      rd;
        logic            rel;
        logic            fire;
        logic [15:0]     target;
    } t_burst;

    // one output byte, NL expanded to CR NL when enabled
    function automatic t_burst emit_tx(logic [7:0] ch, logic onlcr);
        t_burst b;
        b = '0;
        b.txv = 1'b1;
        if (onlcr && ch == CH_NL) begin
            b.bytes[0] = CH_CR;
            b.bytes[1] = CH_NL;
            b.cnt      = 3'd2;
        end else begin
            b.bytes[0] = ch;
            b.cnt      = 3'd1;
        end
        return b;
    endfunction

endpackage

@@ rtl/tld_out_seq.sv @@
// Result sequencer: holds the results of one item and hands them out one per cycle while not stalled.
// Depends on tld_pkg.
module tld_out_seq (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_load,
    input  tld_pkg::t_burst   i_burst,
    output logic              o_free,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output tld_pkg::t_result  o_out_data
);

    logic [2:0]      r_cnt;
    logic [1:0]      r_idx;
    tld_pkg::t_burst r_burst;
    logic            last_now;
    logic            out_acc;

    assign last_now    = ({1'b0, r_idx} == (r_cnt - 3'd1));
    assign o_out_valid = (r_cnt != 3'd0);
    assign out_acc     = o_out_valid && !i_out_stall;
    assign o_free      = !o_out_valid || (out_acc && last_now);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 3'd0;
            r_idx <= 2'd0;
        end else if (i_load) begin
            r_cnt <= i_burst.cnt;
            r_idx <= 2'd0;
        end else if (out_acc) begin
            if (last_now) begin
                r_cnt <= 3'd0;
            end else begin
                r_idx <= r_idx + 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_burst <= i_burst;
        end
    end

    always_comb begin
        o_out_data                  = '0;
        o_out_data.tx_valid         = r_burst.txv;
        o_out_data.tx_char          = r_burst.txv ? r_burst.bytes[r_idx] : tld_pkg::CH_NUL;
        o_out_data.read_valid       = r_burst.rv;
        o_out_data.read_data        = r_burst.rd;
        o_out_data.read_ends_line   = r_burst.rel;
        // interrupt rides on the first result only
        o_out_data.interrupt_fire   = r_burst.fire && (r_idx == 2'd0);
        o_out_data.interrupt_target = (r_burst.fire && r_idx == 2'd0) ? r_burst.target : 16'd0;
        o_out_data.last             = last_now;
    end

`ifndef NO_ASSERTIONS
    a_idx_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt != 3'd0) |-> ({1'b0, r_idx} < r_cnt))
        else $error("result index past burst length");
    a_load_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_load |-> (o_free && i_burst.cnt != 3'd0))
        else $error("burst loaded over pending results");
`endif

endmodule

@@ rtl/tty_line_discipline_unit.sv @@
// Top level of the tty line discipline: line store memory, item stage, config registers.
// Depends on tld_pkg and tld_out_seq.
//
//  channel  direction  handshake                 payload
//  in       to block   i_in_valid / o_in_stall   i_in_data  (tld_pkg::t_item)
//  out      from block o_out_valid / i_out_stall o_out_data (tld_pkg::t_result)
//  cfg      to block   i_cfg_we                  i_cfg_index, i_cfg_data
//
// An item is taken while its line store read is issued, resolved the next cycle,
// and its 0 to 4 results leave the result sequencer at one per cycle while the
// output is not stalled.
// Reset clears positions, counts and config; the store needs no clearing pass.
// o_in_stall rises while the resolved item waits for the sequencer to drain.
module tty_line_discipline_unit #(
    parameter int LINE_DEPTH = tld_pkg::LINE_DEPTH_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  tld_pkg::t_item                  i_in_data,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output tld_pkg::t_result                o_out_data,
    input  logic                            i_cfg_we,
    input  logic [tld_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [tld_pkg::CFG_W-1:0]       i_cfg_data
);

    localparam int AW = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;
    localparam int PW = $clog2(LINE_DEPTH + 1);
    localparam logic [PW-1:0] DEPTH_P  = PW'(LINE_DEPTH);
    localparam logic [PW-1:0] DEPTH_M1 = PW'(LINE_DEPTH - 1);
    localparam logic [PW-1:0] ONE_P    = PW'(1);

    // configuration
    logic        r_canon, r_echo, r_crnl, r_sig, r_onlcr;
    logic [7:0]  r_intr, r_eof;
    logic [15:0] r_fg;

    // line state
    logic [7:0]    mem [LINE_DEPTH];
    logic [PW-1:0] r_wp, r_rp, r_pc;
    logic [PW-1:0] n_wp, n_rp, n_pc;
    logic [PW-1:0] b_wp, b_rp, b_pc;

    // item stage
    logic           r_b_valid;
    tld_pkg::t_item r_b_item;
    logic [7:0]     r_mem_q;
    logic           r_fwd;
    logic [7:0]     r_fwd_data;

    logic            in_acc;
    logic            b_done;
    logic            q_free;
    logic            mem_we;
    logic            b_store;
    logic [7:0]      b_wdata;
    logic [AW-1:0]   waddr;
    logic [AW-1:0]   raddr;
    logic [PW-1:0]   wp_m1;
    logic [7:0]      d;
    logic [7:0]      c;
    logic [7:0]      c2;
    logic            rd_term;
    tld_pkg::t_burst b_burst;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_canon <= 1'b1;
            r_echo  <= 1'b1;
            r_crnl  <= 1'b1;
            r_sig   <= 1'b1;
            r_onlcr <= 1'b1;
            r_intr  <= tld_pkg::INTR_RST;
            r_eof   <= tld_pkg::EOF_RST;
            r_fg    <= 16'd0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                tld_pkg::CFG_CANON: r_canon <= i_cfg_data[0];
                tld_pkg::CFG_ECHO:  r_echo  <= i_cfg_data[0];
                tld_pkg::CFG_CRNL:  r_crnl  <= i_cfg_data[0];
                tld_pkg::CFG_SIG:   r_sig   <= i_cfg_data[0];
                tld_pkg::CFG_ONLCR: r_onlcr <= i_cfg_data[0];
                tld_pkg::CFG_INTR:  r_intr  <= i_cfg_data[7:0];
                tld_pkg::CFG_EOF:   r_eof   <= i_cfg_data[7:0];
                tld_pkg::CFG_FG:    r_fg    <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    assign d       = r_fwd ? r_fwd_data : r_mem_q;
    assign c       = r_b_item.char_in;
    assign rd_term = (d == tld_pkg::CH_NL) || (d == r_eof);

    // resolve the held item against the store data
    always_comb begin
        b_burst = '0;
        b_wp    = r_wp;
        b_rp    = r_rp;
        b_pc    = r_pc;
        b_store = 1'b0;
        b_wdata = c;
        c2      = c;
        if (r_b_valid) begin
            case (r_b_item.req_type)
                tld_pkg::REQ_RX: begin
                    if (c != tld_pkg::CH_NUL && !c[7]) begin
                        if (r_sig && c == r_intr) begin
                            if (r_fg != 16'd0) begin
                                if (r_echo) begin
                                    b_burst.txv      = 1'b1;
                                    b_burst.bytes[0] = tld_pkg::CH_CARET;
                                    b_burst.bytes[1] = tld_pkg::CH_C;
                                    if (r_onlcr) begin
                                        b_burst.bytes[2] = tld_pkg::CH_CR;
                                        b_burst.bytes[3] = tld_pkg::CH_NL;
                                        b_burst.cnt      = 3'd4;
                                    end else begin
                                        b_burst.bytes[2] = tld_pkg::CH_NL;
                                        b_burst.cnt      = 3'd3;
                                    end
                                end else begin
                                    b_burst.cnt = 3'd1;
                                end
                                b_burst.fire   = 1'b1;
                                b_burst.target = r_fg;
                                b_wp = '0;
                                b_rp = '0;
                                b_pc = '0;
                            end
                        end else begin
                            if (c == tld_pkg::CH_CR && r_crnl) begin
                                c2 = tld_pkg::CH_NL;
                            end
                            if (c2 == tld_pkg::CH_BS || c2 == tld_pkg::CH_DEL) begin
                                if (r_wp > r_rp) begin
                                    b_wp = r_wp - ONE_P;
                                    if (rd_term && r_pc != '0) begin
                                        b_pc = r_pc - ONE_P;
                                    end
                                    if (r_echo) begin
                                        b_burst.txv      = 1'b1;
                                        b_burst.bytes[0] = tld_pkg::CH_BS;
                                        b_burst.bytes[1] = tld_pkg::CH_SP;
                                        b_burst.bytes[2] = tld_pkg::CH_BS;
                                        b_burst.cnt      = 3'd3;
                                    end
                                end
                            end else if (r_wp < DEPTH_P) begin
                                // force a newline into the last slot
                                if (r_wp >= DEPTH_M1) begin
                                    c2 = tld_pkg::CH_NL;
                                end
                                b_store = 1'b1;
                                b_wdata = c2;
                                b_wp    = r_wp + ONE_P;
                                if (c2 == tld_pkg::CH_NL || c2 == r_eof) begin
                                    b_pc = r_pc + ONE_P;
                                end
                                if (r_echo) begin
                                    b_burst = tld_pkg::emit_tx(c2, r_onlcr);
                                end
                            end
                        end
                    end
                end
                tld_pkg::REQ_READ: begin
                    b_burst.cnt = 3'd1;
                    if (r_rp < r_wp && !(r_canon && r_pc == '0)) begin
                        b_burst.rv  = 1'b1;
                        b_burst.rd  = d;
                        b_burst.rel = r_canon && rd_term;
                        b_rp        = r_rp + ONE_P;
                        if (rd_term && r_pc != '0) begin
                            b_pc = r_pc - ONE_P;
                        end
                        // drained: rewind both positions
                        if (b_rp == r_wp) begin
                            b_rp = '0;
                            b_wp = '0;
                            b_pc = '0;
                        end
                    end
                end
                tld_pkg::REQ_WRITE: begin
                    b_burst = tld_pkg::emit_tx(c, r_onlcr);
                end
                default: ;
            endcase
        end
    end

    assign b_done     = r_b_valid && (b_burst.cnt == 3'd0 || q_free);
    assign o_in_stall = r_b_valid && !b_done;
    assign in_acc     = i_in_valid && !o_in_stall;

    assign n_wp = b_done ? b_wp : r_wp;
    assign n_rp = b_done ? b_rp : r_rp;
    assign n_pc = b_done ? b_pc : r_pc;

    assign mem_we = b_done && b_store;
    assign waddr  = r_wp[AW-1:0];
    assign wp_m1  = n_wp - ONE_P;
    // read at the read position for reads, below the write position for erases
    assign raddr  = (i_in_data.req_type == tld_pkg::REQ_READ) ? n_rp[AW-1:0] : wp_m1[AW-1:0];

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[waddr] <= b_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_mem_q    <= mem[raddr];
            r_fwd      <= mem_we && (waddr == raddr);
            r_fwd_data <= b_wdata;
            r_b_item   <= i_in_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
            r_wp      <= '0;
            r_rp      <= '0;
            r_pc      <= '0;
        end else begin
            r_wp <= n_wp;
            r_rp <= n_rp;
            r_pc <= n_pc;
            if (in_acc) begin
                r_b_valid <= 1'b1;
            end else if (b_done) begin
                r_b_valid <= 1'b0;
            end
        end
    end

    tld_out_seq u_out_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (b_done && b_burst.cnt != 3'd0),
        .i_burst     (b_burst),
        .o_free      (q_free),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

`ifndef NO_ASSERTIONS
    a_pos_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_rp <= r_wp) && (r_wp <= DEPTH_P))
        else $error("line positions out of order");
    a_store_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mem_we |-> (r_wp < DEPTH_P))
        else $error("store write past the line end");
    a_stall_needs_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (r_b_valid && b_burst.cnt != 3'd0))
        else $error("input stalled without a held transaction");
    a_accept_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> r_b_valid)
        else $error("accepted transaction lost");
`endif

endmodule

@@ sim/tty_line_discipline_unit_tb.sv @@
// Self-checking testbench of tty_line_discipline_unit: a scoreboard class predicts every
// output transaction of the terminal line discipline; plain tasks drive both channels.
// Depends on tld_pkg and the RTL of tty_line_discipline_unit.
module tty_line_discipline_unit_tb;

    localparam int LINE_DEPTH = tld_pkg::LINE_DEPTH_DEF;
    localparam int AW         = $clog2(LINE_DEPTH);

    class tty_scoreboard;
        tld_pkg::t_result expected_q[$];
        tld_pkg::t_result burst[$];
        int               errors;
        bit               canon;
        bit               echo;
        bit               crnl;
        bit               sig;
        bit               onlcr;
        logic [7:0]       intr_ch;
        logic [7:0]       eof_ch;
        logic [15:0]      fg_id;
        logic [7:0]       line_mem[LINE_DEPTH];
        int               wr_pos;
        int               rd_pos;
        int               term_cnt;

        function new();
            errors   = 0;
            canon    = 1'b1;
            echo     = 1'b1;
            crnl     = 1'b1;
            sig      = 1'b1;
            onlcr    = 1'b1;
            intr_ch  = tld_pkg::INTR_RST;
            eof_ch   = tld_pkg::EOF_RST;
            fg_id    = '0;
            wr_pos   = 0;
            rd_pos   = 0;
            term_cnt = 0;
        endfunction

        function void set_reg(logic [tld_pkg::CFG_IDX_W-1:0] idx,
                              logic [tld_pkg::CFG_W-1:0] val);
            case (idx)
                tld_pkg::CFG_CANON: canon   = val[0];
                tld_pkg::CFG_ECHO:  echo    = val[0];
                tld_pkg::CFG_CRNL:  crnl    = val[0];
                tld_pkg::CFG_SIG:   sig     = val[0];
                tld_pkg::CFG_ONLCR: onlcr   = val[0];
                tld_pkg::CFG_INTR:  intr_ch = val[7:0];
                tld_pkg::CFG_EOF:   eof_ch  = val[7:0];
                tld_pkg::CFG_FG:    fg_id   = val;
                default: ;
            endcase
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function bit is_term(logic [7:0] ch);
            return ch == tld_pkg::CH_NL || ch == eof_ch;
        endfunction

        // output path: NL goes out as CR NL when enabled
        function void push_tx(logic [7:0] ch);
            tld_pkg::t_result r;
            r = '0;
            r.tx_valid = 1'b1;
            if (onlcr && ch == tld_pkg::CH_NL) begin
                r.tx_char = tld_pkg::CH_CR;
                burst.push_back(r);
            end
            r.tx_char = ch;
            burst.push_back(r);
        endfunction

        function void rx_char(logic [7:0] ch_in);
            logic [7:0] c;
            c = ch_in;
            if (c == tld_pkg::CH_NUL || c[7])
                return;
            if (sig && c == intr_ch) begin
                if (fg_id == '0)
                    return;
                if (echo) begin
                    push_tx(tld_pkg::CH_CARET);
                    push_tx(tld_pkg::CH_C);
                    push_tx(tld_pkg::CH_NL);
                end else begin
                    burst.push_back('0);
                end
                burst[0].interrupt_fire   = 1'b1;
                burst[0].interrupt_target = fg_id;
                wr_pos   = 0;
                rd_pos   = 0;
                term_cnt = 0;
                return;
            end
            if (c == tld_pkg::CH_CR && crnl)
                c = tld_pkg::CH_NL;
            if (c == tld_pkg::CH_BS || c == tld_pkg::CH_DEL) begin
                // erase never goes below the read position
                if (wr_pos > rd_pos && wr_pos <= LINE_DEPTH) begin
                    wr_pos--;
                    if (is_term(line_mem[AW'(wr_pos)]) && term_cnt > 0)
                        term_cnt--;
                    if (echo) begin
                        push_tx(tld_pkg::CH_BS);
                        push_tx(tld_pkg::CH_SP);
                        push_tx(tld_pkg::CH_BS);
                    end
                end
                return;
            end
            if (wr_pos >= LINE_DEPTH)
                return;
            if (wr_pos >= LINE_DEPTH - 1)
                c = tld_pkg::CH_NL;
            line_mem[AW'(wr_pos)] = c;
            wr_pos++;
            if (is_term(c))
                term_cnt++;
            if (echo)
                push_tx(c);
        endfunction

        function void read_byte();
            tld_pkg::t_result r;
            bit               ready;
            logic [7:0]       b;
            bit               ends;
            r     = '0;
            ready = rd_pos < wr_pos && wr_pos <= LINE_DEPTH;
            if (canon && term_cnt == 0)
                ready = 1'b0;
            if (!ready) begin
                burst.push_back(r);
                return;
            end
            b = line_mem[AW'(rd_pos)];
            rd_pos++;
            ends = is_term(b);
            if (ends && term_cnt > 0)
                term_cnt--;
            if (rd_pos == wr_pos) begin
                rd_pos   = 0;
                wr_pos   = 0;
                term_cnt = 0;
            end
            r.read_valid     = 1'b1;
            r.read_data      = b;
            r.read_ends_line = canon & ends;
            burst.push_back(r);
        endfunction

        function void note_item(tld_pkg::t_item it);
            burst.delete();
            case (it.req_type)
                tld_pkg::REQ_RX:    rx_char(it.char_in);
                tld_pkg::REQ_READ:  read_byte();
                tld_pkg::REQ_WRITE: push_tx(it.char_in);
                default: ;
            endcase
            if (burst.size() > 0) begin
                burst[burst.size() - 1].last = 1'b1;
                foreach (burst[i])
                    expected_q.push_back(burst[i]);
            end
        endfunction

        function string show(tld_pkg::t_result r);
            return $sformatf("tx=%0d/%02h rd=%0d/%02h/%0d intr=%0d/%04h last=%0d",
                             r.tx_valid, r.tx_char, r.read_valid, r.read_data,
                             r.read_ends_line, r.interrupt_fire, r.interrupt_target, r.last);
        endfunction

        function void check_result(tld_pkg::t_result got);
            tld_pkg::t_result want;
            if (expected_q.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("unexpected result: expected none, got %s", show(got));
                return;
            end
            want = expected_q.pop_front();
            if (got !== want) begin
                errors++;
                if (errors <= 10)
                    $display("mismatch: expected %s, got %s", show(want), show(got));
            end
        endfunction
    endclass

    logic                          i_clk     = 1'b0;
    logic                          rst_n     = 1'b0;
    logic                          in_valid  = 1'b0;
    logic                          in_stall;
    tld_pkg::t_item                in_data   = '0;
    logic                          out_valid;
    logic                          out_stall = 1'b0;
    tld_pkg::t_result              out_data;
    logic                          cfg_we    = 1'b0;
    logic [tld_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic [tld_pkg::CFG_W-1:0]     cfg_data  = '0;

    tty_scoreboard sb;
    bit            calm     = 1'b0;
    int            out_hold = 0;

    tty_line_discipline_unit #(
        .LINE_DEPTH(LINE_DEPTH)
    ) i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (rst_n),
        .i_in_valid (in_valid),
        .o_in_stall (in_stall),
        .i_in_data  (in_data),
        .o_out_valid(out_valid),
        .i_out_stall(out_stall),
        .o_out_data (out_data),
        .i_cfg_we   (cfg_we),
        .i_cfg_index(cfg_index),
        .i_cfg_data (cfg_data)
    );

    always #4 i_clk = ~i_clk;

    function automatic tld_pkg::t_item mk_item(logic [1:0] rq, logic [7:0] ch);
        tld_pkg::t_item it;
        it.req_type = rq;
        it.char_in  = ch;
        return it;
    endfunction

    task automatic send_item(input tld_pkg::t_item it);
        in_valid <= 1'b1;
        in_data  <= it;
        do @(posedge i_clk); while (in_stall);
        sb.note_item(it);
        if (!calm && $urandom_range(0, 5) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge i_clk);
        end
    endtask

    // hold the sender until every expected transaction is out, then let the pipe settle
    task automatic wait_idle();
        in_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic apply_config(input logic [7:0][tld_pkg::CFG_W-1:0] vals);
        wait_idle();
        for (int i = 0; i < 8; i++) begin
            cfg_we    <= 1'b1;
            cfg_index <= i[tld_pkg::CFG_IDX_W-1:0];
            cfg_data  <= vals[i];
            @(posedge i_clk);
            sb.set_reg(i[tld_pkg::CFG_IDX_W-1:0], vals[i]);
        end
        cfg_we <= 1'b0;
    endtask

    function automatic logic [7:0][tld_pkg::CFG_W-1:0] random_config();
        logic [7:0][tld_pkg::CFG_W-1:0] v;
        for (int i = 0; i < 5; i++)
            v[i] = tld_pkg::CFG_W'($urandom_range(0, 1));
        v[tld_pkg::CFG_INTR] = tld_pkg::CFG_W'($urandom_range(1, 127));
        v[tld_pkg::CFG_EOF]  = tld_pkg::CFG_W'($urandom_range(0, 255));
        v[tld_pkg::CFG_FG]   = tld_pkg::CFG_W'($urandom_range(0, 65535));
        return v;
    endfunction

    function automatic logic [7:0] typed_char();
        int pick;
        pick = $urandom_range(0, 19);
        if (pick < 2)
            return tld_pkg::CH_BS;
        if (pick < 3)
            return tld_pkg::CH_DEL;
        if (pick < 4)
            return sb.intr_ch;
        return 8'($urandom_range(8'h20, 8'h7E));
    endfunction

    // mostly typed lines followed by reads, the rest raw noise
    task automatic run_random(input int n_items);
        int         sent;
        int         len;
        int         n_rd;
        logic [7:0] term;
        sent = 0;
        while (sent < n_items) begin
            if ($urandom_range(0, 9) < 7) begin
                len  = $urandom_range(1, 10);
                n_rd = $urandom_range(len, len + 3);
                repeat (len) send_item(mk_item(tld_pkg::REQ_RX, typed_char()));
                case ($urandom_range(0, 2))
                    0: term = tld_pkg::CH_NL;
                    1: term = tld_pkg::CH_CR;
                    default: term = sb.eof_ch;
                endcase
                send_item(mk_item(tld_pkg::REQ_RX, term));
                repeat (n_rd) send_item(mk_item(tld_pkg::REQ_READ, 8'h00));
                sent += len + 1 + n_rd;
            end else begin
                send_item(mk_item(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255))));
                sent++;
            end
        end
    endtask

    // receiver: random stall bursts, plus a long hold-off on request
    initial begin
        int stall_left;
        stall_left = 0;
        forever begin
            @(posedge i_clk);
            if (out_hold > 0) begin
                out_stall <= 1'b1;
                out_hold--;
            end else if (stall_left > 0) begin
                out_stall <= 1'b1;
                stall_left--;
            end else if (!calm && $urandom_range(0, 7) == 0) begin
                out_stall  <= 1'b1;
                stall_left = $urandom_range(1, 14) - 1;
            end else begin
                out_stall <= 1'b0;
            end
        end
    end

    initial begin
        forever begin
            @(posedge i_clk);
            if (rst_n && out_valid && !out_stall)
                sb.check_result(out_data);
        end
    end

    initial begin
        #4000000;
        $display("DONE: errors detected");
        $finish;
    end

    initial begin
        logic [7:0][tld_pkg::CFG_W-1:0] cfg;
        sb = new();
        repeat (3) @(posedge i_clk);
        rst_n <= 1'b1;
        @(posedge i_clk);

        // directed, reset configuration: no interrupt target yet
        send_item(mk_item(tld_pkg::REQ_RX, tld_pkg::INTR_RST));
        send_item(mk_item(tld_pkg::REQ_RX, tld_pkg::CH_NUL));
        send_item(mk_item(tld_pkg::REQ_RX, 8'h80));
        send_item(mk_item(tld_pkg::REQ_RX, 8'hFF));
        send_item(mk_item(tld_pkg::REQ_READ, 8'h00));
        send_item(mk_item(tld_pkg::REQ_RX, tld_pkg::CH_BS));
        send_item(mk_item(tld_pkg::REQ_RX, 8'h61));
        send_item(mk_item(tld_pkg::REQ_RX, tld_pkg::CH_DEL));
        send_item(mk_item(tld_pkg::REQ_RX, 8'h62));
        send_item(mk_item(tld_pkg::REQ_RX, tld_pkg::CH_CR));
        send_item(mk_item(tld_pkg::REQ_READ, 8'h00));
        send_item(mk_item(tld_pkg::REQ_READ, 8'hFF));
        send_item(mk_item(tld_pkg::REQ_RX, tld_pkg::EOF_RST));
        send_item(mk_item(tld_pkg::REQ_READ, 8'h00));
        send_item(mk_item(tld_pkg::REQ_WRITE, tld_pkg::CH_NUL));
        send_item(mk_item(tld_pkg::REQ_WRITE, 8'hFF));
        send_item(mk_item(tld_pkg::REQ_WRITE, tld_pkg::CH_NL));
        send_item(mk_item(2'd3, 8'hAA));
        send_item(mk_item(tld_pkg::REQ_RX, 8'h78));
        send_item(mk_item(tld_pkg::REQ_RX, tld_pkg::CH_NL));
        send_item(mk_item(tld_pkg::REQ_RX, tld_pkg::CH_DEL));
        send_item(mk_item(tld_pkg::REQ_READ, 8'h00));

        cfg = '0;
        for (int i = 0; i < 5; i++)
            cfg[i] = 16'h0001;
        cfg[tld_pkg::CFG_INTR] = {8'h00, tld_pkg::INTR_RST};
        cfg[tld_pkg::CFG_EOF]  = {8'h00, tld_pkg::EOF_RST};
        cfg[tld_pkg::CFG_FG]   = 16'hFFFF;
        apply_config(cfg);
        send_item(mk_item(tld_pkg::REQ_RX, 8'h41));
        send_item(mk_item(tld_pkg::REQ_RX, tld_pkg::INTR_RST));
        send_item(mk_item(tld_pkg::REQ_READ, 8'h00));

        // fill the line store to the top while the receiver holds off
        cfg[tld_pkg::CFG_ONLCR] = '0;
        cfg[tld_pkg::CFG_FG]    = 16'h0042;
        apply_config(cfg);
        out_hold = 300;
        repeat (LINE_DEPTH + 2)
            send_item(mk_item(tld_pkg::REQ_RX, 8'($urandom_range(8'h20, 8'h7E))));
        send_item(mk_item(tld_pkg::REQ_RX, tld_pkg::CH_BS));
        send_item(mk_item(tld_pkg::REQ_RX, 8'h7A));
        // take a few bytes, then flush the rest with an interrupt
        repeat (4) send_item(mk_item(tld_pkg::REQ_READ, 8'h00));
        send_item(mk_item(tld_pkg::REQ_RX, tld_pkg::INTR_RST));
        send_item(mk_item(tld_pkg::REQ_READ, 8'h00));

        cfg = '0;
        for (int i = 0; i < 5; i++)
            cfg[i] = 16'h0001;
        cfg[tld_pkg::CFG_INTR] = {8'h00, tld_pkg::INTR_RST};
        cfg[tld_pkg::CFG_EOF]  = {8'h00, tld_pkg::EOF_RST};
        cfg[tld_pkg::CFG_FG]   = 16'h0001;
        apply_config(cfg);
        run_random(10);

        cfg = '0;
        apply_config(cfg);
        run_random(10);

        for (int i = 0; i < 5; i++)
            cfg[i] = 16'h0001;
        cfg[tld_pkg::CFG_INTR] = 16'h00FF;
        cfg[tld_pkg::CFG_EOF]  = 16'h00FF;
        cfg[tld_pkg::CFG_FG]   = 16'hFFFF;
        apply_config(cfg);
        run_random(10);

        // interrupt on DEL, CR kept raw and used as end of line
        cfg = '0;
        cfg[tld_pkg::CFG_CANON] = 16'h0001;
        cfg[tld_pkg::CFG_SIG]   = 16'h0001;
        cfg[tld_pkg::CFG_INTR]  = {8'h00, tld_pkg::CH_DEL};
        cfg[tld_pkg::CFG_EOF]   = {8'h00, tld_pkg::CH_CR};
        cfg[tld_pkg::CFG_FG]    = 16'hA5A5;
        apply_config(cfg);
        run_random(10);

        apply_config(random_config());
        run_random(10);

        apply_config(random_config());
        calm = 1'b1;
        run_random(10);

        wait_idle();
        if (sb.errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
